// ===== src/glu_pkg.sv =====
// ============================================================================
// GCD/LCM unit package
// Shared widths and types for the GCD and LCM unit.
// ============================================================================
package glu_pkg;

   localparam int OPERAND_BITS = 31;
   localparam int PRODUCT_BITS = 2 * OPERAND_BITS;
   localparam int SUB_BITS     = OPERAND_BITS + 1;
   localparam int CNT_BITS     = $clog2(OPERAND_BITS);

   typedef struct packed {
      logic idle;
      logic done;
   } glu_stat_type;

endpackage

// ===== src/glu_sub.sv =====
// ============================================================================
// GCD/LCM shared subtractor
// The one subtract and compare unit that both the GCD loop and the divider use.
// ============================================================================
module glu_sub (
   input  logic [glu_pkg::SUB_BITS-1:0] op_a,
   input  logic [glu_pkg::SUB_BITS-1:0] op_b,
   output logic [glu_pkg::SUB_BITS-1:0] diff,
   output logic                         borrow
);
   import glu_pkg::*;

   assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

// ===== src/glu_core.sv =====
// ============================================================================
// GCD/LCM sequencer
// Binary GCD, restoring division of a by the GCD, then one multiply by b.
// ============================================================================
module glu_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             take,
   input  logic [glu_pkg::OPERAND_BITS-1:0] op_a,
   input  logic [glu_pkg::OPERAND_BITS-1:0] op_b,
   output glu_pkg::glu_stat_type            status,
   output logic [glu_pkg::OPERAND_BITS-1:0] gcd,
   output logic [glu_pkg::PRODUCT_BITS-1:0] lcm
);
   import glu_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GCD  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [OPERAND_BITS-1:0] x_ff, x_in;
   logic [OPERAND_BITS-1:0] y_ff, y_in;
   logic [OPERAND_BITS-1:0] q_ff, q_in;
   logic [OPERAND_BITS-1:0] b_ff, b_in;
   logic [OPERAND_BITS-1:0] g_ff, g_in;
   logic [OPERAND_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0]     k_ff, k_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    zero_ff, zero_in;
   logic [PRODUCT_BITS-1:0] lcm_ff, lcm_in;

   logic [SUB_BITS-1:0]     sub_a, sub_b, sub_diff, neg_diff, rem_sh;
   logic                    sub_borrow;
   logic [OPERAND_BITS-1:0] gcd_shift;

   glu_sub u_sub (
      .op_a   (sub_a),
      .op_b   (sub_b),
      .diff   (sub_diff),
      .borrow (sub_borrow)
   );

   always_comb begin
      rem_sh    = {rem_ff, q_ff[OPERAND_BITS-1]};
      neg_diff  = ~sub_diff + SUB_BITS'(1);
      gcd_shift = (x_ff | y_ff) << k_ff;
      if (state_ff == S_DIV) begin
         sub_a = rem_sh;
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, y_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      q_in     = q_ff;
      b_in     = b_ff;
      g_in     = g_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      zero_in  = zero_ff;
      lcm_in   = lcm_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in     = op_a;
               y_in     = op_b;
               q_in     = op_a;
               b_in     = op_b;
               k_in     = '0;
               zero_in  = (op_a == '0) || (op_b == '0);
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if ((x_ff == '0) || (y_ff == '0)) begin
               g_in = gcd_shift;
               if (zero_ff) begin
                  lcm_in   = '0;
                  state_in = S_DONE;
               end else begin
                  rem_in   = '0;
                  cnt_in   = CNT_BITS'(OPERAND_BITS - 1);
                  state_in = S_DIV;
               end
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + CNT_BITS'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!sub_borrow) begin
               x_in = sub_diff[OPERAND_BITS-1:0] >> 1;
            end else begin
               y_in = neg_diff[OPERAND_BITS-1:0] >> 1;
            end
         end
         S_DIV: begin
            rem_in = sub_borrow ? rem_sh[OPERAND_BITS-1:0] : sub_diff[OPERAND_BITS-1:0];
            q_in   = {q_ff[OPERAND_BITS-2:0], ~sub_borrow};
            if (cnt_ff == '0) begin
               state_in = S_MUL;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         S_MUL: begin
            lcm_in   = {{OPERAND_BITS{1'b0}}, q_ff} * {{OPERAND_BITS{1'b0}}, b_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      q_ff    <= q_in;
      b_ff    <= b_in;
      g_ff    <= g_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      lcm_ff  <= lcm_in;
   end

   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_DONE);
   assign gcd         = g_ff;
   assign lcm         = lcm_ff;

   a_start_enters_gcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && start |=> (state_ff == S_GCD))
      else $error("Accepted operands did not start the GCD loop.");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < g_ff))
      else $error("Division remainder is not below the divisor.");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (g_ff != '0) && !zero_ff)
      else $error("Multiply step reached with a zero divisor.");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && !take |=> (state_ff == S_DONE) && $stable(lcm_ff))
      else $error("Finished result changed before it was taken.");

endmodule

// ===== src/gcd_lcm_unit.sv =====
// ============================================================================
// GCD and LCM unit
// Returns the greatest common divisor and exact least common multiple of two
// unsigned operands.
// ============================================================================
// Usage: present a pair of operands on req_a and req_b with req_valid; the
// transaction is accepted when req_ready is also high. Exactly one result
// transaction follows on rsp_gcd and rsp_lcm under rsp_valid and rsp_ready.
// A zero operand gives the other operand as the GCD and zero as the LCM.
// The sequencer first runs the binary GCD loop (each step drops at least one
// operand bit), then leaves the loop, divides a by the GCD one quotient bit
// at a time (31 quotient bits), multiplies the quotient by b and passes the
// result into the output register. With a zero operand the division and
// multiply are skipped. One operand pair is worked at a time through the
// single shared subtractor, so req_ready is high only while the sequencer
// is idle.
// A finished result sits in the output register; while the receiver stalls,
// the sequencer may take and work a new pair and then holds its result
// until the output register frees. Synchronous reset empties the output
// register and returns the sequencer to idle.
// ============================================================================
module gcd_lcm_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [glu_pkg::OPERAND_BITS-1:0] req_a,
   input  logic [glu_pkg::OPERAND_BITS-1:0] req_b,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [glu_pkg::OPERAND_BITS-1:0] rsp_gcd,
   output logic [glu_pkg::PRODUCT_BITS-1:0] rsp_lcm
);
   import glu_pkg::*;

   glu_stat_type            status;
   logic                    start, take;
   logic [OPERAND_BITS-1:0] core_gcd;
   logic [PRODUCT_BITS-1:0] core_lcm;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0] rsp_gcd_ff;
   logic [PRODUCT_BITS-1:0] rsp_lcm_ff;

   glu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .take   (take),
      .op_a   (req_a),
      .op_b   (req_b),
      .status (status),
      .gcd    (core_gcd),
      .lcm    (core_lcm)
   );

   assign req_ready = status.idle;
   assign start     = req_valid && status.idle;
   assign take      = status.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_gcd_ff <= core_gcd;
         rsp_lcm_ff <= core_lcm;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gcd   = rsp_gcd_ff;
   assign rsp_lcm   = rsp_lcm_ff;

endmodule
